[rtl/core/impq_pkg.sv]
// ----------------------------------------------------------------------------
// impq_pkg
// Shared types, constants and helpers of the indexed max priority queue.
// ----------------------------------------------------------------------------
package impq_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;
	localparam int ID_COUNT = 64;

	localparam int ID_W   = $clog2(ID_COUNT);
	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int IDX_W  = SLOT_W + 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ENT_W  = KEY_BITS + ID_W;

	typedef enum logic [1:0] {
		MODE_INS = 2'd0,
		MODE_EXT = 2'd1,
		MODE_UPD = 2'd2,
		MODE_RSV = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [ID_W-1:0]     id;
	} entry_t;

	typedef struct packed {
		mode_t               mode;
		logic [KEY_BITS-1:0] item_key;
		logic [ID_W-1:0]     item_id;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [KEY_BITS-1:0] removed_key;
		logic [ID_W-1:0]     removed_id;
		logic                top_valid;
		logic [KEY_BITS-1:0] top_key;
		logic [ID_W-1:0]     top_id;
		logic [CNT_W-1:0]    entry_count;
	} rsp_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_LOAD,
		C_FAIL,
		C_INS,
		C_EX_START,
		C_EX_ROOT,
		C_EX_TAKE,
		C_RD_MAP,
		C_UPD_TAKE,
		C_RD_PARENT,
		C_UP_MOVE,
		C_RD_LEFT,
		C_RD_RIGHT,
		C_DN_MOVE,
		C_PLACE,
		C_TOP_RD
	} cmd_t;

	typedef struct packed {
		mode_t   mode;
		status_t check;
		logic    pos_root;
		logic    last_root;
		logic    up_gt;
		logic    l_in;
		logic    dn_gt;
		logic    out_free;
	} stat_t;

	typedef struct packed {
		cmd_t op;
		logic emit;
	} ctl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_EX_ROOT,
		S_EX_TAKE,
		S_MAP_WAIT,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_PLACE,
		S_TOP_RD,
		S_TOP_CAP
	} state_t;

	// strict greater-than; with sgn set, signed order by flipping the sign bit
	function automatic logic key_gt(input logic [KEY_BITS-1:0] a,
	                                input logic [KEY_BITS-1:0] b,
	                                input logic sgn);
		logic [KEY_BITS-1:0] flip;
		flip = '0;
		flip[KEY_BITS-1] = sgn;
		return (a ^ flip) > (b ^ flip);
	endfunction

endpackage

[rtl/core/impq_req_if.sv]
// ----------------------------------------------------------------------------
// impq_req_if
// Request channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface impq_req_if;
	logic                          valid;
	logic                          ready;
	impq_pkg::mode_t               mode;
	logic [impq_pkg::KEY_BITS-1:0] item_key;
	logic [impq_pkg::ID_W-1:0]     item_id;

	modport source (output valid, output mode, output item_key, output item_id, input ready);
	modport sink (input valid, input mode, input item_key, input item_id, output ready);
endinterface

[rtl/core/impq_rsp_if.sv]
// ----------------------------------------------------------------------------
// impq_rsp_if
// Result channel: valid/ready handshake with status, removed entry and top.
// ----------------------------------------------------------------------------
interface impq_rsp_if;
	logic                          valid;
	logic                          ready;
	impq_pkg::status_t             status;
	logic [impq_pkg::KEY_BITS-1:0] removed_key;
	logic [impq_pkg::ID_W-1:0]     removed_id;
	logic                          top_valid;
	logic [impq_pkg::KEY_BITS-1:0] top_key;
	logic [impq_pkg::ID_W-1:0]     top_id;
	logic [impq_pkg::CNT_W-1:0]    entry_count;

	modport source (output valid, output status, output removed_key, output removed_id,
		output top_valid, output top_key, output top_id, output entry_count, input ready);
	modport sink (input valid, input status, input removed_key, input removed_id,
		input top_valid, input top_key, input top_id, input entry_count, output ready);
endinterface

[rtl/core/indexed_max_priority_queue_core.sv]
// A request is checked, then sifted, then gives its result: an insert climbs toward
//   the root; an extract that empties the heap goes straight to the result, else it
//   sifts down from the root; an update climbs and then descends; a failed request
//   goes straight to the result. One request at a time: a new one is accepted
//   only once the last result is in the output register. Reset clears count,
//   presence bits, key order, output valid and sequencer state.
// ----------------------------------------------------------------------------
// indexed_max_priority_queue_core
// Indexed binary max-heap with insert, extract-max and key update.
// ----------------------------------------------------------------------------
module indexed_max_priority_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	impq_req_if.sink    req,
	impq_rsp_if.source  rsp
);
	impq_pkg::stat_t stat;
	impq_pkg::ctl_t  ctl;
	impq_pkg::req_t  req_pl;
	impq_pkg::rsp_t  rsp_pl;

	assign req_pl.mode     = req.mode;
	assign req_pl.item_key = req.item_key;
	assign req_pl.item_id  = req.item_id;

	impq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	impq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_pl),
		.ctl         (ctl),
		.stat        (stat),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out         (rsp_pl)
	);

	// drive the result channel
	assign rsp.status      = rsp_pl.status;
	assign rsp.removed_key = rsp_pl.removed_key;
	assign rsp.removed_id  = rsp_pl.removed_id;
	assign rsp.top_valid   = rsp_pl.top_valid;
	assign rsp.top_key     = rsp_pl.top_key;
	assign rsp.top_id      = rsp_pl.top_id;
	assign rsp.entry_count = rsp_pl.entry_count;
endmodule

[rtl/core/impq_ram.sv]
// ----------------------------------------------------------------------------
// impq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module impq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port, and read port that holds its data when idle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

[rtl/core/impq_dpath.sv]
// ----------------------------------------------------------------------------
// impq_dpath
// Heap datapath: slot and id-map memories, moving entry, compares, result.
// ----------------------------------------------------------------------------
module impq_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  impq_pkg::req_t     req,
	input  impq_pkg::ctl_t     ctl,
	output impq_pkg::stat_t    stat,
	output logic               out_valid,
	input  logic               out_ready,
	output impq_pkg::rsp_t     out
);
	impq_pkg::mode_t                 mode_q;
	logic [impq_pkg::KEY_BITS-1:0]   key_q;
	logic [impq_pkg::ID_W-1:0]       id_q;
	impq_pkg::entry_t                cur_q;
	impq_pkg::entry_t                lft_q;
	logic                            r_ok_q;
	logic [impq_pkg::SLOT_W-1:0]     pos_q;
	logic [impq_pkg::CNT_W-1:0]      fill_q;
	logic [impq_pkg::ID_COUNT-1:0]   present_q;
	logic                            signed_q;
	impq_pkg::status_t               status_q;
	impq_pkg::entry_t                rem_q;
	logic                            out_valid_q;
	impq_pkg::rsp_t                  out_q;

	impq_pkg::entry_t                hp_rd;
	impq_pkg::entry_t                hp_wdata;
	logic                            hp_we;
	logic                            hp_re;
	logic [impq_pkg::SLOT_W-1:0]     hp_raddr;
	logic                            mp_we;
	logic [impq_pkg::ID_W-1:0]       mp_waddr;
	logic                            mp_re;
	logic [impq_pkg::SLOT_W-1:0]     mp_rd;

	logic [impq_pkg::IDX_W-1:0]      l_idx;
	logic [impq_pkg::IDX_W-1:0]      r_idx;
	logic [impq_pkg::SLOT_W-1:0]     par_idx;
	logic [impq_pkg::CNT_W-1:0]      last_cnt;
	logic                            take_l;
	impq_pkg::entry_t                child;
	logic [impq_pkg::SLOT_W-1:0]     child_idx;
	impq_pkg::status_t               check;
	logic                            r_in;

	// neighbor slots of the hole
	assign l_idx    = impq_pkg::IDX_W'({pos_q, 1'b1});
	assign r_idx    = l_idx + 1'b1;
	assign par_idx  = (pos_q - 1'b1) >> 1;
	assign last_cnt = fill_q - 1'b1;
	assign r_in     = r_idx < impq_pkg::IDX_W'(fill_q);

	// larger child, right child on a tie
	assign take_l    = !r_ok_q || impq_pkg::key_gt(lft_q.key, hp_rd.key, signed_q);
	assign child     = take_l ? lft_q : hp_rd;
	assign child_idx = take_l ? l_idx[impq_pkg::SLOT_W-1:0] : r_idx[impq_pkg::SLOT_W-1:0];

	// request check against count and presence
	always_comb begin
		case (mode_q)
			impq_pkg::MODE_INS: begin
				if (fill_q == impq_pkg::CNT_W'(impq_pkg::CAPACITY))
					check = impq_pkg::ST_FULL;
				else if (present_q[id_q])
					check = impq_pkg::ST_BAD;
				else
					check = impq_pkg::ST_OK;
			end
			impq_pkg::MODE_EXT: check = (fill_q == '0) ? impq_pkg::ST_EMPTY : impq_pkg::ST_OK;
			impq_pkg::MODE_UPD: check = present_q[id_q] ? impq_pkg::ST_OK : impq_pkg::ST_BAD;
			default:            check = impq_pkg::ST_BAD;
		endcase
	end

	assign stat.mode      = mode_q;
	assign stat.check     = check;
	assign stat.pos_root  = (pos_q == '0);
	assign stat.last_root = (fill_q == impq_pkg::CNT_W'(1));
	assign stat.up_gt     = impq_pkg::key_gt(cur_q.key, hp_rd.key, signed_q);
	assign stat.l_in      = l_idx < impq_pkg::IDX_W'(fill_q);
	assign stat.dn_gt     = impq_pkg::key_gt(child.key, cur_q.key, signed_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	// memory port steering
	always_comb begin
		hp_re    = 1'b0;
		hp_raddr = '0;
		hp_we    = 1'b0;
		hp_wdata = cur_q;
		mp_we    = 1'b0;
		mp_waddr = cur_q.id;
		mp_re    = 1'b0;
		case (ctl.op)
			impq_pkg::C_EX_START, impq_pkg::C_TOP_RD: begin
				hp_re = 1'b1;
			end
			impq_pkg::C_EX_ROOT: begin
				hp_re    = 1'b1;
				hp_raddr = last_cnt[impq_pkg::SLOT_W-1:0];
			end
			impq_pkg::C_RD_PARENT: begin
				hp_re    = 1'b1;
				hp_raddr = par_idx;
			end
			impq_pkg::C_RD_LEFT: begin
				hp_re    = 1'b1;
				hp_raddr = l_idx[impq_pkg::SLOT_W-1:0];
			end
			impq_pkg::C_RD_RIGHT: begin
				hp_re    = r_in;
				hp_raddr = r_idx[impq_pkg::SLOT_W-1:0];
			end
			impq_pkg::C_RD_MAP: begin
				mp_re = 1'b1;
			end
			impq_pkg::C_UP_MOVE: begin
				hp_we    = 1'b1;
				hp_wdata = hp_rd;
				mp_we    = 1'b1;
				mp_waddr = hp_rd.id;
			end
			impq_pkg::C_DN_MOVE: begin
				hp_we    = 1'b1;
				hp_wdata = child;
				mp_we    = 1'b1;
				mp_waddr = child.id;
			end
			impq_pkg::C_PLACE: begin
				hp_we = 1'b1;
				mp_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	impq_ram #(.WIDTH(impq_pkg::ENT_W), .DEPTH(impq_pkg::CAPACITY)) u_heap (
		.clk     (clk),
		.wr_en   (hp_we),
		.wr_addr (pos_q),
		.wr_data (hp_wdata),
		.rd_en   (hp_re),
		.rd_addr (hp_raddr),
		.rd_data (hp_rd)
	);

	impq_ram #(.WIDTH(impq_pkg::SLOT_W), .DEPTH(impq_pkg::ID_COUNT)) u_map (
		.clk     (clk),
		.wr_en   (mp_we),
		.wr_addr (mp_waddr),
		.wr_data (pos_q),
		.rd_en   (mp_re),
		.rd_addr (id_q),
		.rd_data (mp_rd)
	);

	// control state: count, presence, key order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			present_q <= '0;
			signed_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				signed_q <= cfg_wr_data;
			end
			case (ctl.op)
				impq_pkg::C_INS: begin
					fill_q           <= fill_q + 1'b1;
					present_q[id_q]  <= 1'b1;
				end
				impq_pkg::C_EX_TAKE: begin
					fill_q              <= last_cnt;
					present_q[rem_q.id] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers of the request in flight
	always_ff @(posedge clk) begin
		case (ctl.op)
			impq_pkg::C_LOAD: begin
				mode_q   <= req.mode;
				key_q    <= req.item_key;
				id_q     <= req.item_id;
				status_q <= impq_pkg::ST_OK;
				rem_q    <= '0;
			end
			impq_pkg::C_FAIL: status_q <= check;
			impq_pkg::C_INS: begin
				cur_q <= '{key: key_q, id: id_q};
				pos_q <= fill_q[impq_pkg::SLOT_W-1:0];
			end
			impq_pkg::C_EX_ROOT: rem_q <= hp_rd;
			impq_pkg::C_EX_TAKE: begin
				cur_q <= hp_rd;
				pos_q <= '0;
			end
			impq_pkg::C_UPD_TAKE: begin
				cur_q <= '{key: key_q, id: id_q};
				pos_q <= mp_rd;
			end
			impq_pkg::C_UP_MOVE: pos_q <= par_idx;
			impq_pkg::C_RD_RIGHT: begin
				lft_q  <= hp_rd;
				r_ok_q <= r_in;
			end
			impq_pkg::C_DN_MOVE: pos_q <= child_idx;
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_q.status      <= status_q;
			out_q.removed_key <= rem_q.key;
			out_q.removed_id  <= rem_q.id;
			out_q.top_valid   <= (fill_q != '0);
			out_q.top_key     <= (fill_q != '0) ? hp_rd.key : '0;
			out_q.top_id      <= (fill_q != '0) ? hp_rd.id : '0;
			out_q.entry_count <= fill_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out       = out_q;
endmodule

[rtl/core/impq_ctrl.sv]
// ----------------------------------------------------------------------------
// impq_ctrl
// Sequencer: walks each request through check, sift up/down and result.
// ----------------------------------------------------------------------------
module impq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  impq_pkg::stat_t stat,
	output impq_pkg::ctl_t  ctl
);
	impq_pkg::state_t state_q;
	impq_pkg::state_t state_nxt;
	logic             upd;

	assign upd = (stat.mode == impq_pkg::MODE_UPD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= impq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			impq_pkg::S_IDLE: if (req_valid) state_nxt = impq_pkg::S_DEC;
			impq_pkg::S_DEC: begin
				if (stat.check != impq_pkg::ST_OK)
					state_nxt = impq_pkg::S_TOP_RD;
				else if (stat.mode == impq_pkg::MODE_INS)
					state_nxt = impq_pkg::S_UP_RD;
				else if (stat.mode == impq_pkg::MODE_EXT)
					state_nxt = impq_pkg::S_EX_ROOT;
				else
					state_nxt = impq_pkg::S_MAP_WAIT;
			end
			impq_pkg::S_EX_ROOT:  state_nxt = impq_pkg::S_EX_TAKE;
			impq_pkg::S_EX_TAKE:
				state_nxt = stat.last_root ? impq_pkg::S_TOP_RD : impq_pkg::S_DN_RDL;
			impq_pkg::S_MAP_WAIT: state_nxt = impq_pkg::S_UP_RD;
			impq_pkg::S_UP_RD: begin
				if (!stat.pos_root)
					state_nxt = impq_pkg::S_UP_CMP;
				else
					state_nxt = upd ? impq_pkg::S_DN_RDL : impq_pkg::S_PLACE;
			end
			impq_pkg::S_UP_CMP: begin
				if (stat.up_gt)
					state_nxt = impq_pkg::S_UP_RD;
				else
					state_nxt = upd ? impq_pkg::S_DN_RDL : impq_pkg::S_PLACE;
			end
			impq_pkg::S_DN_RDL:
				state_nxt = stat.l_in ? impq_pkg::S_DN_RDR : impq_pkg::S_PLACE;
			impq_pkg::S_DN_RDR: state_nxt = impq_pkg::S_DN_CMP;
			impq_pkg::S_DN_CMP:
				state_nxt = stat.dn_gt ? impq_pkg::S_DN_RDL : impq_pkg::S_PLACE;
			impq_pkg::S_PLACE:  state_nxt = impq_pkg::S_TOP_RD;
			impq_pkg::S_TOP_RD: state_nxt = impq_pkg::S_TOP_CAP;
			impq_pkg::S_TOP_CAP: if (stat.out_free) state_nxt = impq_pkg::S_IDLE;
			default: state_nxt = impq_pkg::S_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		req_ready = 1'b0;
		ctl.op    = impq_pkg::C_NONE;
		ctl.emit  = 1'b0;
		case (state_q)
			impq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) ctl.op = impq_pkg::C_LOAD;
			end
			impq_pkg::S_DEC: begin
				if (stat.check != impq_pkg::ST_OK)
					ctl.op = impq_pkg::C_FAIL;
				else if (stat.mode == impq_pkg::MODE_INS)
					ctl.op = impq_pkg::C_INS;
				else if (stat.mode == impq_pkg::MODE_EXT)
					ctl.op = impq_pkg::C_EX_START;
				else
					ctl.op = impq_pkg::C_RD_MAP;
			end
			impq_pkg::S_EX_ROOT:  ctl.op = impq_pkg::C_EX_ROOT;
			impq_pkg::S_EX_TAKE:  ctl.op = impq_pkg::C_EX_TAKE;
			impq_pkg::S_MAP_WAIT: ctl.op = impq_pkg::C_UPD_TAKE;
			impq_pkg::S_UP_RD: if (!stat.pos_root) ctl.op = impq_pkg::C_RD_PARENT;
			impq_pkg::S_UP_CMP: if (stat.up_gt) ctl.op = impq_pkg::C_UP_MOVE;
			impq_pkg::S_DN_RDL: if (stat.l_in) ctl.op = impq_pkg::C_RD_LEFT;
			impq_pkg::S_DN_RDR:   ctl.op = impq_pkg::C_RD_RIGHT;
			impq_pkg::S_DN_CMP: if (stat.dn_gt) ctl.op = impq_pkg::C_DN_MOVE;
			impq_pkg::S_PLACE:    ctl.op = impq_pkg::C_PLACE;
			impq_pkg::S_TOP_RD:   ctl.op = impq_pkg::C_TOP_RD;
			impq_pkg::S_TOP_CAP:  ctl.emit = stat.out_free;
			default: begin
			end
		endcase
	end
endmodule
